// ===== rtl/core/abstat_pkg.sv =====
// Shared constants and types for the audio block statistics core.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package abstat_pkg;

   // Slot word and sample geometry
   localparam int RAW_W        = 32;
   localparam int SAMPLE_SHIFT = 8;
   localparam int SAMPLE_W     = RAW_W - SAMPLE_SHIFT;

   // Width of the reported sample, zero and flat totals
   localparam int TOTAL_W = 10;

   // Default block capacity in samples
   localparam int MAX_FRAMES_DEF = 512;

   // Reset values of the running extremes
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Status of the block queue between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/core/abstat_req_if.sv =====
// Sample channel: valid/ready handshake carrying one raw slot word.
// Depends on abstat_pkg.
`timescale 1ns / 1ps

interface abstat_req_if import abstat_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RAW_W-1:0]    raw_word;
   logic                last_of_block;

   modport source (output valid, raw_word, last_of_block, input ready);
   modport sink   (input valid, raw_word, last_of_block, output ready);
endinterface

// ===== rtl/core/abstat_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one block's statistics.
// Depends on abstat_pkg.
`timescale 1ns / 1ps

interface abstat_rsp_if import abstat_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] min_value;
   logic signed [SAMPLE_W-1:0] max_value;
   logic signed [SAMPLE_W-1:0] mean_value;
   logic        [SAMPLE_W-1:0] rms_value;
   logic        [TOTAL_W-1:0]  zero_total;
   logic        [TOTAL_W-1:0]  flat_total;
   logic        [TOTAL_W-1:0]  sample_total;
   logic                       overflow;

   modport source (output valid, min_value, max_value, mean_value, rms_value,
                   zero_total, flat_total, sample_total, overflow, input ready);
   modport sink   (input valid, min_value, max_value, mean_value, rms_value,
                   zero_total, flat_total, sample_total, overflow, output ready);
endinterface

// ===== rtl/core/abstat_front.sv =====
// Front end: takes sample transfers, squares them, and accumulates block statistics.
// Depends on abstat_pkg and abstat_req_if; pushes finished blocks to abstat_queue.
`timescale 1ns / 1ps

module abstat_front import abstat_pkg::*; #(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1),
   localparam int SUM_W  = SAMPLE_W + CNT_W,
   localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   abstat_req_if.sink                 req_bus,
   input  q_stat_type                 q_stat,
   output logic                       push,
   output logic signed [SAMPLE_W-1:0] snap_min,
   output logic signed [SAMPLE_W-1:0] snap_max,
   output logic        [CNT_W-1:0]    snap_zero,
   output logic        [CNT_W-1:0]    snap_flat,
   output logic        [CNT_W-1:0]    snap_cnt,
   output logic signed [SUM_W-1:0]    snap_sum,
   output logic        [SQ_W-1:0]     snap_sumsq,
   output logic                       snap_drop
);

   localparam int PROD_W = 2 * SAMPLE_W - 1;

   // Input stage registers
   logic                       a_valid_ff, a_valid_in;
   logic signed [SAMPLE_W-1:0] a_sample_ff;
   logic        [PROD_W-1:0]   a_square_ff;
   logic                       a_last_ff;

   // Accumulator registers
   logic        [CNT_W-1:0]    cnt_ff;
   logic signed [SAMPLE_W-1:0] min_ff;
   logic signed [SAMPLE_W-1:0] max_ff;
   logic signed [SAMPLE_W-1:0] first_ff, first_in;
   logic        [CNT_W-1:0]    zero_ff;
   logic        [CNT_W-1:0]    flat_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic        [SQ_W-1:0]     sumsq_ff;
   logic                       drop_ff;

   logic signed [SAMPLE_W-1:0]   sample_in;
   logic signed [2*SAMPLE_W-1:0] prod;
   logic                         accept;
   logic                         a_adv;
   logic                         room;
   logic signed [SAMPLE_W-1:0]   first_eff;

   // Extract and square the incoming sample
   assign sample_in = req_bus.raw_word[RAW_W-1 -: SAMPLE_W];
   assign prod      = sample_in * sample_in;

   // Advance the input stage unless a block end meets a full queue
   assign a_adv         = a_valid_ff && (!a_last_ff || !q_stat.full);
   assign req_bus.ready = !a_valid_ff || a_adv;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_sample_ff <= sample_in;
         a_square_ff <= prod[PROD_W-1:0];
         a_last_ff   <= req_bus.last_of_block;
      end
   end

   // Compute the statistics after this sample; drop it once the block is full
   assign room      = cnt_ff < CNT_W'(MAX_FRAMES);
   assign first_eff = (cnt_ff == '0) ? a_sample_ff : first_ff;

   always_comb begin
      snap_min   = min_ff;
      snap_max   = max_ff;
      snap_zero  = zero_ff;
      snap_flat  = flat_ff;
      snap_cnt   = cnt_ff;
      snap_sum   = sum_ff;
      snap_sumsq = sumsq_ff;
      snap_drop  = drop_ff | !room;
      first_in   = first_ff;
      if (room) begin
         first_in   = first_eff;
         snap_min   = (a_sample_ff < min_ff) ? a_sample_ff : min_ff;
         snap_max   = (a_sample_ff > max_ff) ? a_sample_ff : max_ff;
         snap_zero  = zero_ff + CNT_W'(a_sample_ff == '0);
         snap_flat  = flat_ff + CNT_W'(a_sample_ff == first_eff);
         snap_cnt   = cnt_ff + 1'b1;
         snap_sum   = sum_ff + SUM_W'(a_sample_ff);
         snap_sumsq = sumsq_ff + SQ_W'(a_square_ff);
      end
   end

   assign push = a_adv && a_last_ff;

   // Update the running state; clear it when the block ends
   always_ff @(posedge clock) begin
      if (reset || push) begin
         cnt_ff   <= '0;
         min_ff   <= SAMPLE_MAX;
         max_ff   <= SAMPLE_MIN;
         first_ff <= '0;
         zero_ff  <= '0;
         flat_ff  <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (a_adv) begin
         cnt_ff   <= snap_cnt;
         min_ff   <= snap_min;
         max_ff   <= snap_max;
         first_ff <= first_in;
         zero_ff  <= snap_zero;
         flat_ff  <= snap_flat;
         sum_ff   <= snap_sum;
         sumsq_ff <= snap_sumsq;
         drop_ff  <= snap_drop;
      end
   end

endmodule

// ===== rtl/core/abstat_queue.sv =====
// Two-entry queue of finished block snapshots between front and back.
// Depends on abstat_pkg for the status struct.
`timescale 1ns / 1ps

module abstat_queue import abstat_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output q_stat_type        q_stat
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        fill_ff, fill_in;

   assign q_stat.full  = fill_ff == 2'd2;
   assign q_stat.empty = fill_ff == 2'd0;
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // Store the snapshot at the write pointer
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/abstat_back.sv =====
// Back end: divides sum and sum of squares by the count, takes the square root,
// and holds the result for the output. Depends on abstat_pkg and abstat_rsp_if.
`timescale 1ns / 1ps

module abstat_back import abstat_pkg::*; #(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1),
   localparam int SUM_W  = SAMPLE_W + CNT_W,
   localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  q_stat_type                 q_stat,
   output logic                       pop,
   input  logic signed [SAMPLE_W-1:0] in_min,
   input  logic signed [SAMPLE_W-1:0] in_max,
   input  logic        [CNT_W-1:0]    in_zero,
   input  logic        [CNT_W-1:0]    in_flat,
   input  logic        [CNT_W-1:0]    in_cnt,
   input  logic signed [SUM_W-1:0]    in_sum,
   input  logic        [SQ_W-1:0]     in_sumsq,
   input  logic                       in_drop,
   abstat_rsp_if.source               rsp_bus
);

   localparam int RT_W   = (SQ_W + 1) / 2;
   localparam int RAD_W  = 2 * RT_W;
   localparam int STEP_W = $clog2(SQ_W + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Working registers of the block in flight
   logic signed [SAMPLE_W-1:0] min_ff;
   logic signed [SAMPLE_W-1:0] max_ff;
   logic        [CNT_W-1:0]    zero_ff;
   logic        [CNT_W-1:0]    flat_ff;
   logic        [CNT_W-1:0]    cnt_ff;
   logic                       drop_ff;
   logic                       neg_ff;
   logic        [SQ_W-1:0]     sdiv_ff, sdiv_in;
   logic        [CNT_W:0]      srem_ff, srem_in;
   logic        [SQ_W-1:0]     qdiv_ff, qdiv_in;
   logic        [CNT_W:0]      qrem_ff, qrem_in;
   logic        [RAD_W-1:0]    rad_ff, rad_in;
   logic        [RT_W-1:0]     root_ff, root_in;
   logic        [RT_W+1:0]     rrem_ff, rrem_in;

   // Output register
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_min_ff;
   logic signed [SAMPLE_W-1:0] out_max_ff;
   logic signed [SAMPLE_W-1:0] out_mean_ff;
   logic        [SAMPLE_W-1:0] out_rms_ff;
   logic        [TOTAL_W-1:0]  out_zero_ff;
   logic        [TOTAL_W-1:0]  out_flat_ff;
   logic        [TOTAL_W-1:0]  out_cnt_ff;
   logic                       out_drop_ff;

   logic [SUM_W-1:0]    sum_mag;
   logic [CNT_W:0]      srem_t, qrem_t;
   logic                s_ge, q_ge, r_ge;
   logic [RT_W+2:0]     rrem_t, trial;
   logic [RT_W+2:0]     rrem_d;
   logic                load;
   logic [SAMPLE_W-1:0] quot_lo;

   assign sum_mag = in_sum[SUM_W-1] ? unsigned'(-in_sum) : unsigned'(in_sum);

   // One restoring division step for each quotient
   assign srem_t = {srem_ff[CNT_W-1:0], sdiv_ff[SQ_W-1]};
   assign qrem_t = {qrem_ff[CNT_W-1:0], qdiv_ff[SQ_W-1]};
   assign s_ge   = srem_t >= {1'b0, cnt_ff};
   assign q_ge   = qrem_t >= {1'b0, cnt_ff};

   // One digit step of the square root
   assign rrem_t = {rrem_ff[RT_W:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign r_ge   = rrem_t >= trial;
   assign rrem_d = rrem_t - trial;

   assign pop  = (state_ff == ST_IDLE) && !q_stat.empty;
   assign load = (state_ff == ST_HOLD) && (!out_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      sdiv_in  = sdiv_ff;
      srem_in  = srem_ff;
      qdiv_in  = qdiv_ff;
      qrem_in  = qrem_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      rrem_in  = rrem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               sdiv_in  = SQ_W'(sum_mag);
               srem_in  = '0;
               qdiv_in  = in_sumsq;
               qrem_in  = '0;
               step_in  = STEP_W'(SQ_W);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            sdiv_in = {sdiv_ff[SQ_W-2:0], s_ge};
            srem_in = s_ge ? (srem_t - {1'b0, cnt_ff}) : srem_t;
            qdiv_in = {qdiv_ff[SQ_W-2:0], q_ge};
            qrem_in = q_ge ? (qrem_t - {1'b0, cnt_ff}) : qrem_t;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               rad_in   = RAD_W'(qdiv_in);
               root_in  = '0;
               rrem_in  = '0;
               step_in  = STEP_W'(RT_W);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            root_in = {root_ff[RT_W-2:0], r_ge};
            rrem_in = r_ge ? rrem_d[RT_W+1:0] : rrem_t[RT_W+1:0];
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Hold the datapath of the block in flight
   always_ff @(posedge clock) begin
      sdiv_ff <= sdiv_in;
      srem_ff <= srem_in;
      qdiv_ff <= qdiv_in;
      qrem_ff <= qrem_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rrem_ff <= rrem_in;
      if (pop) begin
         min_ff  <= in_min;
         max_ff  <= in_max;
         zero_ff <= in_zero;
         flat_ff <= in_flat;
         cnt_ff  <= in_cnt;
         drop_ff <= in_drop;
         neg_ff  <= in_sum[SUM_W-1];
      end
   end

   // Apply the sign of the sum to the truncated quotient
   assign quot_lo = sdiv_ff[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_min_ff  <= min_ff;
         out_max_ff  <= max_ff;
         out_mean_ff <= neg_ff ? (~quot_lo + 1'b1) : quot_lo;
         out_rms_ff  <= root_ff[SAMPLE_W-1:0];
         out_zero_ff <= TOTAL_W'(zero_ff);
         out_flat_ff <= TOTAL_W'(flat_ff);
         out_cnt_ff  <= TOTAL_W'(cnt_ff);
         out_drop_ff <= drop_ff;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.min_value    = out_min_ff;
   assign rsp_bus.max_value    = out_max_ff;
   assign rsp_bus.mean_value   = out_mean_ff;
   assign rsp_bus.rms_value    = out_rms_ff;
   assign rsp_bus.zero_total   = out_zero_ff;
   assign rsp_bus.flat_total   = out_flat_ff;
   assign rsp_bus.sample_total = out_cnt_ff;
   assign rsp_bus.overflow     = out_drop_ff;

endmodule

// ===== rtl/core/audio_block_statistics.sv =====
// Audio block statistics: min, max, mean, RMS, zero and flat counts per block.
// Throughput: one sample transfer per cycle; a block end stalls only while the
// two-entry block queue is full. The shared divide/root unit works through one
// block at a time (divide, then root, then hold), which sets the block rate.
// Each result passes the queue, the divide and root states and the output register.
// Reset (synchronous, active high) clears accumulators, queue and output valid flag.
`timescale 1ns / 1ps

module audio_block_statistics import abstat_pkg::*; #(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   abstat_req_if.sink    req_bus,
   abstat_rsp_if.source  rsp_bus
);

   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;
   localparam int SNAP_W = 1 + 3 * CNT_W + 2 * SAMPLE_W + SUM_W + SQ_W;

   q_stat_type                 q_stat;
   logic                       q_push;
   logic                       q_pop;
   logic [SNAP_W-1:0]          push_data;
   logic [SNAP_W-1:0]          pop_data;

   logic signed [SAMPLE_W-1:0] f_min, b_min;
   logic signed [SAMPLE_W-1:0] f_max, b_max;
   logic        [CNT_W-1:0]    f_zero, b_zero;
   logic        [CNT_W-1:0]    f_flat, b_flat;
   logic        [CNT_W-1:0]    f_cnt, b_cnt;
   logic signed [SUM_W-1:0]    f_sum, b_sum;
   logic        [SQ_W-1:0]     f_sumsq, b_sumsq;
   logic                       f_drop, b_drop;

   abstat_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_stat     (q_stat),
      .push       (q_push),
      .snap_min   (f_min),
      .snap_max   (f_max),
      .snap_zero  (f_zero),
      .snap_flat  (f_flat),
      .snap_cnt   (f_cnt),
      .snap_sum   (f_sum),
      .snap_sumsq (f_sumsq),
      .snap_drop  (f_drop)
   );

   // Pack and unpack the block snapshot
   assign push_data = {f_drop, f_cnt, f_flat, f_zero, f_max, f_min, f_sumsq, f_sum};
   assign {b_drop, b_cnt, b_flat, b_zero, b_max, b_min, b_sumsq, b_sum} = pop_data;

   abstat_queue #(.DATA_W(SNAP_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   abstat_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop      (q_pop),
      .in_min   (b_min),
      .in_max   (b_max),
      .in_zero  (b_zero),
      .in_flat  (b_flat),
      .in_cnt   (b_cnt),
      .in_sum   (b_sum),
      .in_sumsq (b_sumsq),
      .in_drop  (b_drop),
      .rsp_bus  (rsp_bus)
   );

   // A block end never enters a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("block pushed into full queue");

   // The back end only takes a block that is there
   a_pop_held: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("block popped from empty queue");

   // No result is offered straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule
